@@ design/rau_pkg.sv @@
// shared types and constants for the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
  localparam int unsigned Width = 32;
  localparam int unsigned MagW = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_RCP = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_LOAD  = 4'd1,
    CMD_MUL1  = 4'd2,
    CMD_MUL2  = 4'd3,
    CMD_MUL3  = 4'd4,
    CMD_SUM   = 4'd5,
    CMD_GINIT = 4'd6,
    CMD_DSTEP = 4'd7,
    CMD_GSWAP = 4'd8,
    CMD_QINIT = 4'd9,
    CMD_QSTEP = 4'd10,
    CMD_QNEXT = 4'd11,
    CMD_FIN   = 4'd12
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic err;
    logic rem_zero;
    logic div_last;
    logic q_second;
  } sts_t;
endpackage
`default_nettype wire

@@ design/rau_datapath.sv @@
// datapath: operand registers, one shared multiplier, bit-serial divider
// depends on rau_pkg
`default_nettype none
module rau_datapath import rau_pkg::*; (
  input  wire logic                clk,
  input  wire ctl_t                ctl,
  input  wire logic [2:0]          op,
  input  wire logic [Width-1:0]    a_num,
  input  wire logic [Width-1:0]    a_den,
  input  wire logic [Width-1:0]    b_num,
  input  wire logic [Width-1:0]    b_den,
  output sts_t                     sts,
  output logic [Width-1:0]         res_num,
  output logic [Width-2:0]         res_den,
  output logic [1:0]               res_status
);
  logic [Width-1:0] anm, adm, bnm, bdm;
  logic ans, ads, bns, bds;
  logic [2:0] opr;
  logic err;
  logic [MagW-1:0] p1, nmag, dmag;
  logic p1n, nneg, dneg;
  logic [MagW-1:0] ga, gb, rem, quo, dvs;
  logic [5:0] cnt;
  logic qsec;

  logic [MagW-1:0] mul_p, rem_sh;
  logic [Width-1:0] mx, my;
  logic [MagW:0] trial;
  logic bneg_eff, ovf, rneg;
  logic [MagW-1:0] lim;

  function automatic logic [Width-1:0] mag(input logic [Width-1:0] v);
    mag = v[Width-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    mx = anm;
    my = bdm;
    case (ctl.cmd)
      CMD_MUL1: begin
        mx = anm;
        my = (opr == OP_MUL) ? bnm : bdm;
      end
      CMD_MUL2: begin
        mx = (opr == OP_DIV) ? bnm : bnm;
        my = (opr == OP_DIV) ? adm : adm;
      end
      CMD_MUL3: begin
        mx = adm;
        my = (opr == OP_DIV) ? bnm : bdm;
      end
      default: ;
    endcase
  end
  assign mul_p = MagW'(mx) * MagW'(my);
  assign bneg_eff = (opr == OP_SUB) ? (~bns & (bnm != '0)) : bns;
  assign rem_sh = {rem[MagW-2:0], quo[MagW-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs};
  assign lim = MagW'(1) << (Width - 1);
  assign rneg = (nneg != dneg) && (nmag != '0);

  always_comb begin
    ovf = (dmag > lim - 1'b1) || (rneg ? (nmag > lim) : (nmag > lim - 1'b1));
  end

  assign sts.err = err;
  assign sts.rem_zero = (gb == '0);
  assign sts.div_last = (cnt == '0);
  assign sts.q_second = qsec;

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        opr <= op;
        anm <= mag(a_num); ans <= a_num[Width-1];
        adm <= mag(a_den); ads <= a_den[Width-1];
        bnm <= mag(b_num); bns <= b_num[Width-1];
        bdm <= mag(b_den); bds <= b_den[Width-1];
        err <= (op > OP_RCP) || (a_den == '0) ||
               ((op != OP_RCP) && (b_den == '0)) ||
               ((op == OP_DIV) && (b_num == '0)) ||
               ((op == OP_RCP) && (a_num == '0));
      end
      CMD_MUL1: begin
        p1 <= mul_p;
        p1n <= (opr == OP_MUL) ? (ans ^ bns) : (ans ^ bds);
      end
      CMD_MUL2: begin
        // second cross product for add and subtract
        nmag <= mul_p;
        nneg <= (opr == OP_DIV) ? (bns ^ ads) : (bneg_eff ^ ads);
      end
      CMD_MUL3: begin
        dmag <= mul_p;
        dneg <= (opr == OP_DIV) ? (ads ^ bns) : (ads ^ bds);
        if (opr == OP_MUL || opr == OP_DIV) begin
          nmag <= p1;
          nneg <= p1n;
        end else if (opr == OP_RCP) begin
          nmag <= MagW'(adm); nneg <= ads;
          dmag <= MagW'(anm); dneg <= ans;
        end
      end
      CMD_SUM: begin
        if (opr inside {OP_ADD, OP_SUB}) begin
          if ((p1n & (p1 != '0)) == (nneg & (nmag != '0))) begin
            nmag <= p1 + nmag;
            nneg <= p1n & (p1 != '0);
          end else if (p1 >= nmag) begin
            nmag <= p1 - nmag;
            nneg <= p1n;
          end else begin
            nmag <= nmag - p1;
          end
        end
      end
      CMD_GINIT: begin
        ga <= nmag; gb <= dmag; rem <= '0; quo <= nmag;
        dvs <= dmag; cnt <= 6'(MagW - 1);
      end
      CMD_DSTEP: begin
        // one quotient bit per cycle
        if (!trial[MagW]) begin
          rem <= trial[MagW-1:0];
          quo <= {quo[MagW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[MagW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      CMD_GSWAP: begin
        ga <= gb; gb <= rem; rem <= '0; quo <= gb; dvs <= rem;
        cnt <= 6'(MagW - 1);
      end
      CMD_QINIT: begin
        // ga holds the gcd; divide numerator first
        rem <= '0; quo <= nmag; dvs <= ga; qsec <= 1'b0;
        cnt <= 6'(MagW - 1);
      end
      CMD_QNEXT: begin
        nmag <= quo;
        rem <= '0; quo <= dmag; qsec <= 1'b1;
        cnt <= 6'(MagW - 1);
      end
      CMD_QSTEP: begin
        if (!trial[MagW]) begin
          rem <= trial[MagW-1:0];
          quo <= {quo[MagW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[MagW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      CMD_FIN: begin
        if (qsec) dmag <= quo;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_num = '0;
    res_den = '0;
    res_status = ST_DIVZ;
    if (!err) begin
      if (ovf) begin
        res_status = ST_OVF;
      end else begin
        res_status = ST_OK;
        res_num = rneg ? Width'(~nmag + 1'b1) : nmag[Width-1:0];
        res_den = dmag[Width-2:0];
      end
    end
  end
endmodule
`default_nettype wire

@@ design/rau_ctrl.sv @@
// controller state machine sequencing products, gcd and reduction
// depends on rau_pkg
`default_nettype none
module rau_ctrl import rau_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire sts_t sts,
  output ctl_t      ctl,
  output logic      in_rdy,
  output logic      out_vld
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MUL1  = 11'b00000000010,
    S_MUL2  = 11'b00000000100,
    S_MUL3  = 11'b00000001000,
    S_SUM   = 11'b00000010000,
    S_GINIT = 11'b00000100000,
    S_GDIV  = 11'b00001000000,
    S_GSWAP = 11'b00010000000,
    S_QDIV  = 11'b00100000000,
    S_QNEXT = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic gchk;

  always_comb begin
    state_next = state;
    ctl.cmd = CMD_NONE;
    case (state)
      S_IDLE: if (in_fire) begin
        ctl.cmd = CMD_LOAD; state_next = S_MUL1;
      end
      S_MUL1: begin
        ctl.cmd = CMD_MUL1; state_next = sts.err ? S_DONE : S_MUL2;
      end
      S_MUL2: begin ctl.cmd = CMD_MUL2; state_next = S_MUL3; end
      S_MUL3: begin ctl.cmd = CMD_MUL3; state_next = S_SUM; end
      S_SUM: begin ctl.cmd = CMD_SUM; state_next = S_GINIT; end
      S_GINIT: begin ctl.cmd = CMD_GINIT; state_next = S_GDIV; end
      S_GDIV: begin
        ctl.cmd = CMD_DSTEP;
        if (sts.div_last) state_next = S_GSWAP;
      end
      S_GSWAP: begin
        if (sts.rem_zero && gchk) begin
          ctl.cmd = CMD_QINIT; state_next = S_QDIV;
        end else begin
          ctl.cmd = CMD_GSWAP; state_next = S_GDIV;
        end
      end
      S_QDIV: begin
        ctl.cmd = CMD_QSTEP;
        if (sts.div_last) state_next = sts.q_second ? S_DONE : S_QNEXT;
      end
      S_QNEXT: begin ctl.cmd = CMD_QNEXT; state_next = S_QDIV; end
      S_DONE: begin
        if (gchk) ctl.cmd = CMD_FIN;
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gchk <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_GDIV && sts.div_last) gchk <= 1'b1;
      if (state == S_GINIT) gchk <= 1'b0;
      if (state == S_DONE && out_fire) gchk <= 1'b0;
      if (state == S_DONE && gchk) gchk <= 1'b0;
    end
  end

  assign in_rdy = (state == S_IDLE);
  assign out_vld = (state == S_DONE) && !gchk;
endmodule
`default_nettype wire

@@ design/rational_arithmetic_unit_top.sv @@
// rational arithmetic unit: one request of one or two fractions to one reduced fraction
// result waits on the 64-step divider, run per euclid division and for each quotient
// a zero denominator, zero divisor or bad op skips the gcd and reports divide by zero
// one request at a time; a new request is taken once the result has been taken
// synchronous active-high reset returns the controller to idle
// depends on rau_pkg, rau_ctrl, rau_datapath
`default_nettype none
module rational_arithmetic_unit_top import rau_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,  // op, a_num, a_den, b_num, b_den, zero pad
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata   // res_num, res_den, status, zero pad
);
  ctl_t ctl;
  sts_t sts;
  logic [Width-1:0] res_num;
  logic [Width-2:0] res_den;
  logic [1:0] res_status;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_tvalid & s_tready),
    .out_fire(m_tvalid & m_tready),
    .sts(sts), .ctl(ctl), .in_rdy(s_tready), .out_vld(m_tvalid)
  );

  rau_datapath u_dp (
    .clk(clk), .ctl(ctl),
    .op(s_tdata[2:0]), .a_num(s_tdata[34:3]), .a_den(s_tdata[66:35]),
    .b_num(s_tdata[98:67]), .b_den(s_tdata[130:99]),
    .sts(sts), .res_num(res_num), .res_den(res_den), .res_status(res_status)
  );

  assign m_tdata = {7'b0, res_status, res_den, res_num};

`ifndef SYNTHESIS
  a_not_both: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[64:63] != 2'd3) else $error("bad status");
`endif
endmodule
`default_nettype wire

@@ sim/rational_arithmetic_unit_top_tb.sv @@
// testbench for rational_arithmetic_unit_top: directed table then random requests,
// each result checked against the table or a fraction predictor with random stalls on both sides
// depends on rau_pkg and rational_arithmetic_unit_top
`default_nettype none
module rational_arithmetic_unit_top_tb import rau_pkg::*; ();

  localparam int unsigned IdleLimit = 100000;
  localparam int unsigned NumRandom = 1200;
  localparam int unsigned DrainCycles = 8000;

  typedef struct packed {
    status_t     st;
    logic [30:0] den;
    logic [31:0] num;
  } frac_res_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    logic        typed;
    frac_res_t   res;
  } req_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;  // op, a_num, a_den, b_num, b_den, zero pad
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;       // res_num, res_den, status, zero pad

  req_row_t    dir_rows[$];
  frac_res_t   expected_q[$];
  req_row_t    cur_row;
  int          errors = 0;
  int          idle_cycles = 0;
  logic        req_taken = 1'b0;
  logic        hold_off = 1'b0;

  rational_arithmetic_unit_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] mag_of(logic [31:0] v);
    logic [63:0] x;
    x = {{32{v[31]}}, v};
    return v[31] ? -x : x;
  endfunction

  function automatic frac_res_t reduce_fraction(logic [2:0] op, logic [31:0] an_i,
                                                logic [31:0] ad_i, logic [31:0] bn_i,
                                                logic [31:0] bd_i);
    frac_res_t   r;
    logic [63:0] an, ad, bn, bd, p, q, n, d, g, t, lim;
    logic        ann, adn, bnn, bdn, pn, qn, nn, dn, neg;
    r = '{num: '0, den: '0, st: ST_DIVZ};
    an = mag_of(an_i); ad = mag_of(ad_i); bn = mag_of(bn_i); bd = mag_of(bd_i);
    ann = an_i[31]; adn = ad_i[31]; bnn = bn_i[31]; bdn = bd_i[31];
    if (op > OP_RCP || ad == 0) return r;
    if (op != OP_RCP && bd == 0) return r;
    if (op == OP_DIV && bn == 0) return r;
    if (op == OP_RCP && an == 0) return r;
    if (op == OP_SUB && bn != 0) bnn = ~bnn;
    case (op)
      OP_ADD, OP_SUB: begin
        p = an * bd; pn = (ann != bdn) && p != 0;
        q = bn * ad; qn = (bnn != adn) && q != 0;
        if (pn == qn) begin
          n = p + q; nn = pn;
        end else if (p >= q) begin
          n = p - q; nn = pn;
        end else begin
          n = q - p; nn = qn;
        end
        if (n == 0) nn = 1'b0;
        d = ad * bd; dn = adn != bdn;
      end
      OP_MUL: begin
        n = an * bn; nn = ann != bnn;
        d = ad * bd; dn = adn != bdn;
      end
      OP_DIV: begin
        n = an * bd; nn = ann != bdn;
        d = ad * bn; dn = adn != bnn;
      end
      default: begin
        n = ad; nn = adn;
        d = an; dn = ann;
      end
    endcase
    g = n; t = d;
    while (t != 0) begin
      p = g % t; g = t; t = p;
    end
    n = n / g; d = d / g;
    neg = (nn != dn) && n != 0;
    lim = 64'd1 << 31;
    r.st = ST_OVF;
    if (d > lim - 1) return r;
    if (neg ? n > lim : n > lim - 1) return r;
    r.num = neg ? 32'(-n) : n[31:0];
    r.den = d[30:0];
    r.st = ST_OK;
    return r;
  endfunction

  function automatic req_row_t make_row(logic [2:0] op, int an, int ad, int bn, int bd,
                                        logic typed, frac_res_t res);
    req_row_t row;
    row = '{op: op, a_num: an, a_den: ad, b_num: bn, b_den: bd, typed: typed, res: res};
    return row;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 4) == 0 ? 32'd0 : 32'(int'($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return 32'(int'($urandom_range(0, 200000)) - 100000) * $urandom_range(1, 12);
    endcase
  endfunction

  task automatic send_request(req_row_t row);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_row = row;
    s_tdata = {5'b0, row.b_den, row.b_num, row.a_den, row.a_num, row.op};
    s_tvalid = 1'b1;
    do @(negedge clk); while (!req_taken);
  endtask

  // accept side: record the expectation for every request taken
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      req_taken = 1'b1;
      if (cur_row.typed)
        expected_q.push_back(cur_row.res);
      else
        expected_q.push_back(reduce_fraction(cur_row.op, cur_row.a_num, cur_row.a_den,
                                             cur_row.b_num, cur_row.b_den));
    end
  end

  // result side
  always @(posedge clk) begin
    frac_res_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[64:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.num !== want.num || got.den !== want.den || got.st !== want.st) begin
          $display("%0t: mismatch expected num=%0d den=%0d st=%0d actual num=%0d den=%0d st=%0d",
                   $time, $signed(want.num), want.den, want.st,
                   $signed(got.num), got.den, got.st);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL rational_arithmetic_unit_top");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off
  always @(negedge clk) begin
    if (hold_off) m_tready <= 1'b0;
    else if ($urandom_range(0, 15) == 0) m_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) m_tready <= $urandom_range(0, 1);
    else m_tready <= 1'b1;
  end

  initial begin
    repeat (200) @(negedge clk);
    hold_off = 1'b1;
    repeat (5000) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    frac_res_t divz, ovf, none;
    req_row_t  row;
    divz = '{num: '0, den: '0, st: ST_DIVZ};
    ovf = '{num: '0, den: '0, st: ST_OVF};
    none = '{num: '0, den: '0, st: ST_OK};
    dir_rows.push_back(make_row(OP_ADD, 1, 2, 1, 3, 1'b1, '{num: 5, den: 6, st: ST_OK}));
    dir_rows.push_back(make_row(OP_ADD, 0, 5, 0, -7, 1'b1, '{num: 0, den: 1, st: ST_OK}));
    dir_rows.push_back(make_row(OP_SUB, 3, 4, 3, 4, 1'b1, '{num: 0, den: 1, st: ST_OK}));
    dir_rows.push_back(make_row(OP_ADD, 1, 0, 1, 1, 1'b1, divz));
    dir_rows.push_back(make_row(OP_SUB, 1, 1, 1, 0, 1'b1, divz));
    dir_rows.push_back(make_row(OP_MUL, 1, 1, 2, 0, 1'b1, divz));
    dir_rows.push_back(make_row(OP_DIV, 1, 2, 0, 3, 1'b1, divz));
    dir_rows.push_back(make_row(OP_RCP, 0, 3, 9, 0, 1'b1, divz));
    dir_rows.push_back(make_row(OP_RCP, 5, 0, 1, 1, 1'b1, divz));
    dir_rows.push_back(make_row(3'd5, 1, 1, 1, 1, 1'b1, divz));
    dir_rows.push_back(make_row(3'd6, 1, 1, 1, 1, 1'b1, divz));
    dir_rows.push_back(make_row(3'd7, 1, 1, 1, 1, 1'b1, divz));
    dir_rows.push_back(make_row(OP_MUL, 32'h7fffffff, 1, 2, 1, 1'b1, ovf));
    dir_rows.push_back(make_row(OP_RCP, 32'h80000000, 1, 0, 0, 1'b1, ovf));
    dir_rows.push_back(make_row(OP_DIV, 32'h80000000, 1, -1, 1, 1'b1, ovf));
    dir_rows.push_back(make_row(OP_RCP, -3, 6, 0, 0, 1'b1, '{num: -2, den: 1, st: ST_OK}));
    dir_rows.push_back(make_row(OP_MUL, 32'h80000000, 1, 1, 1, 1'b0, none));
    dir_rows.push_back(make_row(OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                32'h80000000, 1'b0, none));
    dir_rows.push_back(make_row(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                32'h80000000, 1'b0, none));
    dir_rows.push_back(make_row(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000,
                                32'h80000000, 1'b0, none));
    dir_rows.push_back(make_row(OP_DIV, -1, -1, 32'h7fffffff, -1, 1'b0, none));
    dir_rows.push_back(make_row(OP_DIV, 32'h12345678, 32'hfedcba98, 32'h80000000,
                                32'h7fffffff, 1'b0, none));

    repeat (11) @(negedge clk);
    rst = 1'b0;
    foreach (dir_rows[i]) send_request(dir_rows[i]);
    for (int i = 0; i < NumRandom; i++) begin
      row.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) :
                                              3'($urandom_range(0, 4));
      row.a_num = rand_operand();
      row.a_den = rand_operand();
      row.b_num = rand_operand();
      row.b_den = rand_operand();
      row.typed = 1'b0;
      row.res = none;
      send_request(row);
    end
    s_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) $display("PASS rational_arithmetic_unit_top");
    else $display("FAIL rational_arithmetic_unit_top");
    $finish;
  end
endmodule
`default_nettype wire
